[hw/rtl/kpc_pkg.sv]
// Shared types, key profile weights and widths for the key profile correlator.
package kpc_pkg;

    localparam int BINS      = 12;
    localparam int NCAND     = 2 * BINS;
    localparam int CHROMA_W  = 16;
    localparam int WEIGHT_W  = 10;
    localparam int PROD_W    = 25;
    localparam int PART_W    = 27;
    localparam int SCORE_W   = 28;
    localparam int IDX_W     = 5;
    localparam int ROOT_W    = 4;
    localparam int CONF_W    = 16;
    localparam int GROUPS    = 6;
    localparam int PARTS     = 3;

    // Saturation point of one chroma bin (2.0).
    localparam logic [CHROMA_W-1:0] CHROMA_MAX = 16'd32768;

    // Confidence is floor(score * 3 / 2500); score * CONF_RECIP >> CONF_SHIFT
    // is at most one below that.
    localparam int CONF_RECIP_W = 19;
    localparam logic [CONF_RECIP_W-1:0] CONF_RECIP = 19'd322122;
    localparam int CONF_SHIFT   = 28;
    localparam int QUOT_W       = 18;
    localparam int WIDE_W       = 30;
    localparam logic [WIDE_W-1:0] CONF_DEN = 30'd2500;
    localparam logic [QUOT_W-1:0] CONF_MAX = 18'd65535;
    localparam logic [SCORE_W-1:0] CONF_SAT_SCORE = 28'd54613334;

    typedef logic [CHROMA_W-1:0] chroma_t;
    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [PROD_W-1:0]   prod_t;
    typedef logic [PART_W-1:0]   part_t;
    typedef logic [SCORE_W-1:0]  score_t;
    typedef logic [IDX_W-1:0]    cand_idx_t;

    // One candidate: index is 2*root + minor.
    typedef struct packed {
        score_t    score;
        cand_idx_t idx;
    } cand_t;

    localparam weight_t MAJOR_W [BINS] = '{
        10'd635, 10'd223, 10'd348, 10'd233, 10'd438, 10'd409,
        10'd252, 10'd519, 10'd239, 10'd366, 10'd229, 10'd288
    };
    localparam weight_t MINOR_W [BINS] = '{
        10'd633, 10'd268, 10'd352, 10'd538, 10'd260, 10'd353,
        10'd254, 10'd475, 10'd398, 10'd269, 10'd334, 10'd317
    };

endpackage

[hw/rtl/key_profile_correlation_top.sv]
// Top level of the key profile correlator: scoring, best-key selection, confidence.
// Stages: 8 register stages in all, from request acceptance to result valid.
// Throughput: one request per cycle unless back-pressure stalls; one item per stage.
// Stall: a stage moves when it is empty or the next stage moves, so bubbles close up.
// Reset: rst_n clears the valid bits only; no state is kept between requests.
module key_profile_correlation_top
    import kpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [15:0]         chroma_c,
    input  logic [15:0]         chroma_cs,
    input  logic [15:0]         chroma_d,
    input  logic [15:0]         chroma_ds,
    input  logic [15:0]         chroma_e,
    input  logic [15:0]         chroma_f,
    input  logic [15:0]         chroma_fs,
    input  logic [15:0]         chroma_g,
    input  logic [15:0]         chroma_gs,
    input  logic [15:0]         chroma_a,
    input  logic [15:0]         chroma_as,
    input  logic [15:0]         chroma_b,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ROOT_W-1:0]   key_root,
    output logic                key_is_minor,
    output logic [SCORE_W-1:0]  best_score,
    output logic [CONF_W-1:0]   key_confidence
);

    localparam int STAGES = 4;
    localparam int PROD_WIDE_W = SCORE_W + CONF_RECIP_W;

    chroma_t chroma [BINS];
    score_t  score  [NCAND];
    logic    corr_valid;
    logic    corr_ready;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] en;

    cand_t              grp_reg [GROUPS];
    cand_t              best_reg;
    cand_t              conf_cand_reg;
    logic [QUOT_W-1:0]  quot_reg;
    cand_t              out_cand_reg;
    logic [CONF_W-1:0]  conf_reg;

    cand_t              grp_next [GROUPS];
    cand_t              best_next;
    logic [PROD_WIDE_W-1:0] quot_prod;
    logic [QUOT_W-1:0]  quot_next;
    logic [WIDE_W-1:0]  triple;
    logic [WIDE_W-1:0]  rem;
    logic [QUOT_W-1:0]  quot_fix;
    logic [CONF_W-1:0]  conf_next;

    // Later candidate wins only on a strictly higher score
    function automatic cand_t pick(input cand_t a, input cand_t b);
        pick = (b.score > a.score) ? b : a;
    endfunction

    assign chroma[0]  = chroma_c;
    assign chroma[1]  = chroma_cs;
    assign chroma[2]  = chroma_d;
    assign chroma[3]  = chroma_ds;
    assign chroma[4]  = chroma_e;
    assign chroma[5]  = chroma_f;
    assign chroma[6]  = chroma_fs;
    assign chroma[7]  = chroma_g;
    assign chroma[8]  = chroma_gs;
    assign chroma[9]  = chroma_a;
    assign chroma[10] = chroma_as;
    assign chroma[11] = chroma_b;

    kpc_correlator u_corr (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .chroma    (chroma),
        .out_valid (corr_valid),
        .out_ready (corr_ready),
        .score     (score)
    );

    // Advance a stage when it is empty or its successor moves
    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign corr_ready = en[0];

    // Reduce 24 candidates to 6, four per group
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            cand_t c0, c1, c2, c3;
            c0 = '{score: score[4*g],   idx: IDX_W'(4*g)};
            c1 = '{score: score[4*g+1], idx: IDX_W'(4*g+1)};
            c2 = '{score: score[4*g+2], idx: IDX_W'(4*g+2)};
            c3 = '{score: score[4*g+3], idx: IDX_W'(4*g+3)};
            grp_next[g] = pick(pick(c0, c1), pick(c2, c3));
        end
    end

    // Reduce 6 group winners to one, keeping index order
    assign best_next = pick(pick(pick(grp_reg[0], grp_reg[1]), pick(grp_reg[2], grp_reg[3])),
                            pick(grp_reg[4], grp_reg[5]));

    // Estimate the confidence quotient by reciprocal multiply
    assign quot_prod = PROD_WIDE_W'(best_reg.score) * PROD_WIDE_W'(CONF_RECIP);
    assign quot_next = quot_prod[CONF_SHIFT +: QUOT_W];

    // Correct the estimate by one and saturate
    always_comb
    begin
        triple   = WIDE_W'(conf_cand_reg.score) * WIDE_W'(3);
        rem      = triple - WIDE_W'(quot_reg) * CONF_DEN;
        quot_fix = (rem >= CONF_DEN) ? quot_reg + QUOT_W'(1) : quot_reg;
        conf_next = (quot_fix > CONF_MAX) ? CONF_MAX[CONF_W-1:0] : quot_fix[CONF_W-1:0];
    end

    // Hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= corr_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            grp_reg <= grp_next;
        end
        if (en[1])
        begin
            best_reg <= best_next;
        end
        if (en[2])
        begin
            conf_cand_reg <= best_reg;
            quot_reg      <= quot_next;
        end
        if (en[3])
        begin
            out_cand_reg <= conf_cand_reg;
            conf_reg     <= conf_next;
        end
    end

    assign out_valid      = valid_reg[STAGES-1];
    assign key_root       = out_cand_reg.idx[IDX_W-1:1];
    assign key_is_minor   = out_cand_reg.idx[0];
    assign best_score     = out_cand_reg.score;
    assign key_confidence = conf_reg;

    // Input stalls only when a result is held at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output back-pressure");

    // Winning root stays within the twelve pitch classes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (key_root <= ROOT_W'(BINS - 1)))
        else $error("key root out of range");

    // Large scores saturate the confidence
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (best_score >= CONF_SAT_SCORE)) |-> (key_confidence == '1))
        else $error("confidence not saturated");

    // Zero score gives zero confidence
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (best_score == '0)) |-> (key_confidence == '0))
        else $error("confidence nonzero for zero score");

endmodule

[hw/rtl/kpc_correlator.sv]
// Four-stage pipeline that forms all 24 rotated profile correlation scores.
module kpc_correlator
    import kpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  chroma_t chroma [BINS],
    output logic    out_valid,
    input  logic    out_ready,
    output score_t  score [NCAND]
);

    localparam int STAGES = 4;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] en;

    chroma_t chroma_reg [BINS];
    prod_t   prod_reg   [NCAND][BINS];
    part_t   part_reg   [NCAND][PARTS];
    score_t  score_reg  [NCAND];

    chroma_t chroma_sat [BINS];
    prod_t   prod_next  [NCAND][BINS];
    part_t   part_next  [NCAND][PARTS];
    score_t  score_next [NCAND];

    // Advance a stage when it is empty or its successor moves
    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[STAGES-1];
    assign score     = score_reg;

    // Saturate bins above 2.0
    always_comb
    begin
        for (int j = 0; j < BINS; j++)
        begin
            chroma_sat[j] = (chroma[j] > CHROMA_MAX) ? CHROMA_MAX : chroma[j];
        end
    end

    // Multiply each rotated bin by its profile weight, one lane per candidate
    always_comb
    begin
        for (int r = 0; r < BINS; r++)
        begin
            for (int i = 0; i < BINS; i++)
            begin
                int p;
                p = r + i;
                if (p >= BINS)
                begin
                    p = p - BINS;
                end
                prod_next[2*r][i]   = PROD_W'(32'(chroma_reg[p]) * 32'(MAJOR_W[i]));
                prod_next[2*r+1][i] = PROD_W'(32'(chroma_reg[p]) * 32'(MINOR_W[i]));
            end
        end
    end

    // Sum products in groups of four, then the three partial sums
    always_comb
    begin
        for (int k = 0; k < NCAND; k++)
        begin
            for (int g = 0; g < PARTS; g++)
            begin
                part_next[k][g] = PART_W'(prod_reg[k][4*g]) + PART_W'(prod_reg[k][4*g+1])
                                + PART_W'(prod_reg[k][4*g+2]) + PART_W'(prod_reg[k][4*g+3]);
            end
            score_next[k] = SCORE_W'(part_reg[k][0]) + SCORE_W'(part_reg[k][1])
                          + SCORE_W'(part_reg[k][2]);
        end
    end

    // Hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            chroma_reg <= chroma_sat;
        end
        if (en[1])
        begin
            prod_reg <= prod_next;
        end
        if (en[2])
        begin
            part_reg <= part_next;
        end
        if (en[3])
        begin
            score_reg <= score_next;
        end
    end

endmodule

[tb/sv/key_profile_correlation_top_test.sv]
// Self-checking testbench for the key profile correlator top level.
`timescale 1ns / 100ps

module key_profile_correlation_top_test
    import kpc_pkg::*;
;

    localparam int NUM_BINS     = 12;
    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 16;
    localparam int FILL_HOLD    = 300;
    localparam int PHASE_FRAMES = 320;
    localparam int MAX_REPORTS  = 10;
    localparam int unsigned BIN_CEILING = 32768;
    localparam int unsigned CONF_CEILING = 65535;

    // Key profiles, weights scaled by 100, index 0 is the tonic
    localparam int unsigned MAJOR_PROFILE [NUM_BINS] = '{
        635, 223, 348, 233, 438, 409, 252, 519, 239, 366, 229, 288
    };
    localparam int unsigned MINOR_PROFILE [NUM_BINS] = '{
        633, 268, 352, 538, 260, 353, 254, 475, 398, 269, 334, 317
    };

    typedef logic [NUM_BINS-1:0][15:0] chroma_frame_t;

    typedef struct packed {
        logic [ROOT_W-1:0]  root;
        logic               minor;
        logic [SCORE_W-1:0] score;
        logic [CONF_W-1:0]  conf;
    } key_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    chroma_frame_t      frame_bus;
    logic               out_valid;
    logic               out_ready;
    logic [ROOT_W-1:0]  key_root;
    logic               key_is_minor;
    logic [SCORE_W-1:0] best_score;
    logic [CONF_W-1:0]  key_confidence;

    key_result_t expected_keys [$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_len;
    int quiet_cycles;
    int mismatch_count;
    int frames_sent;
    int keys_checked;
    int minor_wins;
    int conf_saturated;
    int clipped_frames;

    key_profile_correlation_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .chroma_c       (frame_bus[0]),
        .chroma_cs      (frame_bus[1]),
        .chroma_d       (frame_bus[2]),
        .chroma_ds      (frame_bus[3]),
        .chroma_e       (frame_bus[4]),
        .chroma_f       (frame_bus[5]),
        .chroma_fs      (frame_bus[6]),
        .chroma_g       (frame_bus[7]),
        .chroma_gs      (frame_bus[8]),
        .chroma_a       (frame_bus[9]),
        .chroma_as      (frame_bus[10]),
        .chroma_b       (frame_bus[11]),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .key_root       (key_root),
        .key_is_minor   (key_is_minor),
        .best_score     (best_score),
        .key_confidence (key_confidence)
    );

    // Run the clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Score all 24 candidate keys and keep the first best one
    function automatic key_result_t predict_key(chroma_frame_t frame);
        int unsigned clipped [NUM_BINS];
        int unsigned best;
        int unsigned major_sum;
        int unsigned minor_sum;
        longint unsigned conf;
        key_result_t res;
        best = 0;
        res = '0;
        for (int i = 0; i < NUM_BINS; i++)
            clipped[i] = (frame[i] > BIN_CEILING) ? BIN_CEILING : int'(frame[i]);
        for (int r = 0; r < NUM_BINS; r++)
        begin
            major_sum = 0;
            minor_sum = 0;
            for (int i = 0; i < NUM_BINS; i++)
            begin
                major_sum += clipped[(r + i) % NUM_BINS] * MAJOR_PROFILE[i];
                minor_sum += clipped[(r + i) % NUM_BINS] * MINOR_PROFILE[i];
            end
            // Strict compare keeps the earlier candidate on a tie
            if (r == 0 || major_sum > best)
            begin
                best = major_sum;
                res.root = r[ROOT_W-1:0];
                res.minor = 1'b0;
            end
            if (minor_sum > best)
            begin
                best = minor_sum;
                res.root = r[ROOT_W-1:0];
                res.minor = 1'b1;
            end
        end
        conf = (longint'(best) * 3) / 2500;
        if (conf > CONF_CEILING)
            conf = CONF_CEILING;
        res.score = best[SCORE_W-1:0];
        res.conf = conf[CONF_W-1:0];
        return res;
    endfunction

    // Fill every bin with the same energy
    function automatic chroma_frame_t flat_frame(logic [15:0] level);
        chroma_frame_t frame;
        for (int i = 0; i < NUM_BINS; i++)
            frame[i] = level;
        return frame;
    endfunction

    // Build a triad on a root with light background energy
    function automatic chroma_frame_t triad_frame(int root, bit minor, int noise);
        chroma_frame_t frame;
        for (int i = 0; i < NUM_BINS; i++)
            frame[i] = 16'($urandom_range(0, noise));
        frame[root % NUM_BINS] = 16'($urandom_range(20000, 32768));
        frame[(root + (minor ? 3 : 4)) % NUM_BINS] = 16'($urandom_range(14000, 32768));
        frame[(root + 7) % NUM_BINS] = 16'($urandom_range(12000, 32768));
        return frame;
    endfunction

    // Draw one random frame from a mix of shapes
    function automatic chroma_frame_t random_frame();
        chroma_frame_t frame;
        logic [15:0] motif [6];
        int pick;
        int period;
        pick = $urandom_range(0, 99);
        frame = '0;
        if (pick < 35)
        begin
            frame = triad_frame($urandom_range(0, 11), 1'($urandom_range(0, 1)),
                                $urandom_range(0, 8000));
        end
        else if (pick < 55)
        begin
            for (int i = 0; i < NUM_BINS; i++)
                frame[i] = 16'($urandom_range(0, 32768));
        end
        else if (pick < 70)
        begin
            // Full 16-bit words, many above the nominal range
            for (int i = 0; i < NUM_BINS; i++)
                frame[i] = 16'($urandom);
        end
        else if (pick < 80)
        begin
            for (int i = 0; i < NUM_BINS; i++)
                if ($urandom_range(0, 3) == 0)
                    frame[i] = 16'($urandom);
        end
        else if (pick < 90)
        begin
            // Periodic pattern: several roots score alike, exercising ties
            case ($urandom_range(0, 4))
                0: period = 1;
                1: period = 2;
                2: period = 3;
                3: period = 4;
                default: period = 6;
            endcase
            for (int k = 0; k < 6; k++)
                motif[k] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 32768));
            for (int i = 0; i < NUM_BINS; i++)
                frame[i] = motif[i % period];
        end
        else
        begin
            for (int i = 0; i < NUM_BINS; i++)
                frame[i] = 16'($urandom_range(28000, 65535));
        end
        return frame;
    endfunction

    // Offer one request, hold it until accepted, then queue its expected key
    task automatic send_frame(chroma_frame_t frame);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        frame_bus <= frame;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_keys.insert(expected_keys.size(), predict_key(frame));
        frames_sent++;
        for (int i = 0; i < NUM_BINS; i++)
            if (frame[i] > BIN_CEILING)
            begin
                clipped_frames++;
                break;
            end
    endtask

    // Drop valid and wait until every queued key has come back
    task automatic drain_keys();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_keys.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extremes();
        chroma_frame_t frame;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_frame(flat_frame(16'd0));
        send_frame(flat_frame(16'd32768));
        send_frame(flat_frame(16'd32769));
        send_frame(flat_frame(16'hFFFF));
        send_frame(flat_frame(16'h7FFF));
        send_frame(flat_frame(16'hAAAA));
        send_frame(flat_frame(16'h5555));
        // Flat levels on either side of the confidence saturation point
        send_frame(flat_frame(16'd12269));
        send_frame(flat_frame(16'd12270));
        send_frame(flat_frame(16'd1));
        frame = '0;
        frame[0] = 16'd32768;
        send_frame(frame);
        frame = '0;
        frame[11] = 16'd32768;
        send_frame(frame);
        frame = '0;
        frame[6] = 16'hFFFF;
        send_frame(frame);
        // Clean C major and A minor triads
        frame = '0;
        frame[0] = 16'd32768;
        frame[4] = 16'd32768;
        frame[7] = 16'd32768;
        send_frame(frame);
        frame = '0;
        frame[9] = 16'd32768;
        frame[0] = 16'd32768;
        frame[4] = 16'd32768;
        send_frame(frame);
        for (int i = 0; i < NUM_BINS; i++)
            frame[i] = (i % 2 == 0) ? 16'hAAAA : 16'h5555;
        send_frame(frame);
        for (int i = 0; i < NUM_BINS; i++)
            frame[i] = (i % 6 < 3) ? 16'd30000 : 16'd5000;
        send_frame(frame);
        for (int i = 0; i < NUM_BINS; i++)
            frame[i] = 16'(i * 2730);
        send_frame(frame);
        for (int i = 0; i < NUM_BINS; i++)
            frame[i] = 16'((NUM_BINS - 1 - i) * 2979);
        send_frame(frame);
        drain_keys();
    endtask

    task automatic test_random_frames(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int n = 0; n < PHASE_FRAMES; n++)
            send_frame(random_frame());
        drain_keys();
    endtask

    // Hold the output off long enough for the pipeline to fill and stall input
    task automatic test_output_stall_fill();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_len = FILL_HOLD;
        for (int n = 0; n < 40; n++)
            send_frame(random_frame());
        drain_keys();
    endtask

    // Compare one field and report the first few errors
    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("ERROR %0t: %s expected %0d got %0d", $realtime, field, want, got);
        end
    endtask

    // Check each returned key against the oldest pending one
    always @(posedge clk)
    begin
        key_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_keys.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("ERROR %0t: key returned with no request pending", $realtime);
            end
            else
            begin
                want = expected_keys.pop_front();
                check_field("key_root", want.root, key_root);
                check_field("key_is_minor", want.minor, key_is_minor);
                check_field("best_score", want.score, best_score);
                check_field("key_confidence", want.conf, key_confidence);
                keys_checked++;
                if (want.minor)
                    minor_wins++;
                if (want.conf == CONF_CEILING[CONF_W-1:0])
                    conf_saturated++;
            end
        end
    end

    // Drive out_ready: a counted hold-off first, otherwise random stalls
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                hold_len--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("key_profile_correlation_top: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        frame_bus = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_len = 0;
        quiet_cycles = 0;
        mismatch_count = 0;
        frames_sent = 0;
        keys_checked = 0;
        minor_wins = 0;
        conf_saturated = 0;
        clipped_frames = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_random_frames(0, 0);
        test_random_frames(46, 0);
        test_random_frames(0, 46);
        test_random_frames(32, 32);
        test_output_stall_fill();

        // Let any stray result show up before closing
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_keys.size() != 0)
            mismatch_count++;

        $display("Sent %0d chroma frames, checked %0d keys (%0d minor, %0d at full confidence)",
                 frames_sent, keys_checked, minor_wins, conf_saturated);
        $display("%0d frames carried bins above 2.0; idle, stall and pipeline-fill phases run",
                 clipped_frames);
        if (mismatch_count == 0)
            $display("key_profile_correlation_top: match");
        else
            $display("key_profile_correlation_top: mismatch");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/kpc_pkg.sv
hw/rtl/kpc_correlator.sv
hw/rtl/key_profile_correlation_top.sv
tb/sv/key_profile_correlation_top_test.sv
